### src/sfla_pkg.sv
// shared types, constants and helpers for the segregated free list allocator
package sfla_pkg;

  localparam int HEAP_BYTES    = 65536;
  localparam int GRANULE_BYTES = 8;
  localparam int HEADER_BYTES  = 32;
  localparam int SIZE_CLASSES  = 10;
  localparam int MIN_PAYLOAD   = 16;
  localparam int ENTRIES       = HEAP_BYTES / GRANULE_BYTES;
  localparam int ADDR_W        = $clog2(ENTRIES);
  localparam int IDX_W         = ADDR_W + 1;
  localparam int CLS_W         = $clog2(SIZE_CLASSES);
  localparam int QSLOTS        = 4;

  localparam logic [IDX_W-1:0] NIL      = IDX_W'(ENTRIES);
  localparam logic [15:0]      INIT_LEN = 16'(HEAP_BYTES - HEADER_BYTES);

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NULL     = 3'd1;
  localparam logic [2:0] STAT_TOO_BIG  = 3'd2;
  localparam logic [2:0] STAT_OOM      = 3'd3;
  localparam logic [2:0] STAT_OUTSIDE  = 3'd4;
  localparam logic [2:0] STAT_NOT_HDR  = 3'd5;
  localparam logic [2:0] STAT_DBL_FREE = 3'd6;
  localparam logic [2:0] STAT_DISABLED = 3'd7;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // link field selectors for patches
  localparam logic [1:0] FLD_NC = 2'd0;
  localparam logic [1:0] FLD_PC = 2'd1;
  localparam logic [1:0] FLD_PP = 2'd2;

  // sequencer steps
  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_DEC     = 5'd2;
  localparam logic [4:0] ST_SCAN    = 5'd3;
  localparam logic [4:0] ST_A_CHK   = 5'd4;
  localparam logic [4:0] ST_A_TAKE  = 5'd5;
  localparam logic [4:0] ST_A_SPLIT = 5'd6;
  localparam logic [4:0] ST_A_FIN   = 5'd7;
  localparam logic [4:0] ST_F_CHK   = 5'd8;
  localparam logic [4:0] ST_F_N     = 5'd9;
  localparam logic [4:0] ST_F_P0    = 5'd10;
  localparam logic [4:0] ST_F_P     = 5'd11;
  localparam logic [4:0] ST_F_INS_P = 5'd12;
  localparam logic [4:0] ST_F_WE    = 5'd13;
  localparam logic [4:0] ST_F_INS_E = 5'd14;
  localparam logic [4:0] ST_DRAIN   = 5'd15;
  localparam logic [4:0] ST_DR_RD   = 5'd16;
  localparam logic [4:0] ST_DR_WR   = 5'd17;
  localparam logic [4:0] ST_FIN     = 5'd18;

  typedef struct packed {
    logic        op;
    logic [19:0] request_size;
    logic [15:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_offset;
    logic [16:0] used_bytes;
  } out_item_t;

  // one heap entry, one per granule
  typedef struct packed {
    logic [15:0]      len;
    logic             hdr_mark;
    logic             free_mark;
    logic [IDX_W-1:0] next_phys;
    logic [IDX_W-1:0] prev_phys;
    logic [IDX_W-1:0] next_cls;
    logic [IDX_W-1:0] prev_cls;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] addr;
    logic [1:0]       fld;
    logic [IDX_W-1:0] val;
  } patch_t;

  typedef struct packed {
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic dec_fail;
    logic is_free;
    logic h_nil;
    logic cls_last;
    logic fit;
    logic nxt_nil;
    logic split;
    logic chk_fail;
    logic np_nil;
    logic pp_nil;
    logic p_free;
    logic clr_last;
    logic pending;
    logic more;
    logic out_busy;
  } sts_t;

  // size class of a payload length
  function automatic logic [CLS_W-1:0] class_of(input logic [16:0] len);
    logic [CLS_W-1:0] res;
    logic             found;
    res   = CLS_W'(SIZE_CLASSES - 1);
    found = 1'b0;
    for (int k = 0; k < SIZE_CLASSES - 1; k++) begin
      if (!found && ({1'b0, len} <= (18'd32 << k))) begin
        res   = CLS_W'(k);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

### src/sfla_ram.sv
// generic single-port ram with registered read
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/sfla_ctrl.sv
// sequencer for allocation, free, patch drain and clearing pass
module sfla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  sfla_pkg::sts_t sts,
  output sfla_pkg::cmd_t cmd
);
  import sfla_pkg::*;

  logic [4:0] state, state_next;
  logic [4:0] ret, ret_next;

  // next step
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_CLR:     if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:    if (in_valid) state_next = ST_DEC;
      ST_DEC: begin
        if (sts.dec_fail) state_next = ST_FIN;
        else if (sts.is_free) state_next = ST_F_CHK;
        else state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.h_nil) state_next = ST_A_CHK;
        else if (sts.cls_last) state_next = ST_FIN;
      end
      ST_A_CHK: begin
        if (sts.fit) state_next = ST_A_TAKE;
        else if (sts.nxt_nil) state_next = sts.cls_last ? ST_FIN : ST_SCAN;
      end
      ST_A_TAKE:  state_next = sts.split ? ST_A_SPLIT : ST_A_FIN;
      ST_A_SPLIT: state_next = ST_A_FIN;
      ST_A_FIN: begin
        state_next = ST_DRAIN;
        ret_next   = ST_FIN;
      end
      ST_F_CHK: begin
        if (sts.chk_fail) state_next = ST_FIN;
        else if (sts.np_nil) state_next = ST_F_P0;
        else state_next = ST_F_N;
      end
      ST_F_N: begin
        state_next = ST_DRAIN;
        ret_next   = ST_F_P0;
      end
      ST_F_P0:    state_next = sts.pp_nil ? ST_F_INS_E : ST_F_P;
      ST_F_P:     state_next = sts.p_free ? ST_F_INS_P : ST_F_INS_E;
      ST_F_INS_P: state_next = ST_F_WE;
      ST_F_WE, ST_F_INS_E: begin
        state_next = ST_DRAIN;
        ret_next   = ST_FIN;
      end
      ST_DRAIN:   state_next = sts.pending ? ST_DR_RD : ret;
      ST_DR_RD:   state_next = ST_DR_WR;
      ST_DR_WR:   state_next = sts.more ? ST_DR_RD : ret;
      ST_FIN:     if (!sts.out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      ret   <= ST_FIN;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign cmd.step = state;

endmodule

### src/sfla_dpath.sv
// datapath: entry memory, class heads, patch queue, result register
module sfla_dpath (
  input  logic                clk,
  input  logic                rst,
  input  sfla_pkg::cmd_t      cmd,
  output sfla_pkg::sts_t      sts,
  input  logic                in_valid,
  input  sfla_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                out_stall,
  output logic                out_valid,
  output sfla_pkg::out_item_t out_item
);
  import sfla_pkg::*;

  // request and working registers
  in_item_t          req;
  logic              enable;
  logic [IDX_W-1:0]  heads [SIZE_CLASSES];
  logic [16:0]       used;
  logic [IDX_W-1:0]  cur;
  ent_t              cw;
  ent_t              ow;
  logic [IDX_W-1:0]  oidx;
  logic [16:0]       need;
  logic [CLS_W-1:0]  cls;
  logic [2:0]        stat;
  logic [15:0]       grant;
  logic [ADDR_W-1:0] clr_cnt;
  patch_t            q [QSLOTS];

  // memory port
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  ent_t              dout;
  ent_t              wword;

  sfla_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign dout      = ent_t'(ram_rdata);
  assign ram_wdata = ENT_W'(wword);

  // allocation request decode
  logic [20:0]      need_sum;
  logic [20:0]      need_rnd;
  logic [16:0]      need_c;
  logic             a_fail;
  logic [2:0]       a_stat;
  assign need_sum = {1'b0, req.request_size} + 21'd11;
  assign need_rnd = need_sum & ~21'd7;
  assign need_c   = (need_rnd < 21'(MIN_PAYLOAD)) ? 17'(MIN_PAYLOAD) : need_rnd[16:0];

  always_comb begin
    a_fail = 1'b1;
    a_stat = STAT_OK;
    if (req.request_size == 20'd0) a_stat = STAT_NULL;
    else if (!enable) a_stat = STAT_DISABLED;
    else if (req.request_size > 20'(HEAP_BYTES)) a_stat = STAT_TOO_BIG;
    else a_fail = 1'b0;
  end

  // free request decode
  logic [15:0]      hdr_off;
  logic [IDX_W-1:0] e_idx;
  logic             f_fail;
  logic [2:0]       f_stat;
  assign hdr_off = req.payload_offset - 16'(HEADER_BYTES);
  assign e_idx   = {1'b0, hdr_off[15:3]};

  always_comb begin
    f_fail = 1'b1;
    f_stat = STAT_OK;
    if (req.payload_offset == 16'd0) f_stat = STAT_NULL;
    else if (req.payload_offset < 16'(HEADER_BYTES)) f_stat = STAT_OUTSIDE;
    else if (hdr_off[2:0] != 3'd0) f_stat = STAT_NOT_HDR;
    else f_fail = 1'b0;
  end

  // split geometry
  logic [IDX_W:0]   r_sum;
  logic [IDX_W-1:0] r_idx;
  logic [15:0]      r_len;
  assign r_sum = {1'b0, cur} + (IDX_W+1)'(HEADER_BYTES / GRANULE_BYTES) + {1'b0, need[16:3]};
  assign r_idx = r_sum[IDX_W-1:0];
  assign r_len = cw.len - need[15:0] - 16'(HEADER_BYTES);

  // freed entry and merged previous entry
  ent_t chk_ent;
  ent_t mrg_ent;
  always_comb begin
    chk_ent           = dout;
    chk_ent.free_mark = 1'b1;
    mrg_ent           = dout;
    mrg_ent.len       = dout.len + 16'(HEADER_BYTES) + cw.len;
    mrg_ent.next_phys = cw.next_phys;
  end

  // class head read port
  logic [CLS_W-1:0] h_idx;
  logic [IDX_W-1:0] h_val;
  always_comb begin
    case (cmd.step)
      ST_A_TAKE:         h_idx = class_of({1'b0, cw.len});
      ST_A_SPLIT:        h_idx = class_of({1'b0, r_len});
      ST_F_N, ST_F_P:    h_idx = class_of({1'b0, dout.len});
      ST_F_INS_P:        h_idx = class_of({1'b0, ow.len});
      ST_F_INS_E:        h_idx = class_of({1'b0, cw.len});
      default:           h_idx = cls;
    endcase
  end
  assign h_val = heads[h_idx];

  // patch queue head selection
  logic [1:0] sel;
  logic       any_vld;
  logic [2:0] n_vld;
  always_comb begin
    sel     = 2'd0;
    any_vld = 1'b0;
    n_vld   = 3'd0;
    for (int i = QSLOTS - 1; i >= 0; i--) begin
      if (q[i].vld) begin
        sel     = 2'(i);
        any_vld = 1'b1;
        n_vld   = n_vld + 3'd1;
      end
    end
  end

  ent_t patched;
  always_comb begin
    patched = dout;
    case (q[sel].fld)
      FLD_NC:  patched.next_cls  = q[sel].val;
      FLD_PC:  patched.prev_cls  = q[sel].val;
      default: patched.prev_phys = q[sel].val;
    endcase
  end

  // init entry written at index zero of the clearing pass
  ent_t init_ent;
  always_comb begin
    init_ent           = '0;
    init_ent.len       = INIT_LEN;
    init_ent.hdr_mark  = 1'b1;
    init_ent.free_mark = 1'b1;
    init_ent.next_phys = NIL;
    init_ent.prev_phys = NIL;
    init_ent.next_cls  = NIL;
    init_ent.prev_cls  = NIL;
  end

  // memory address and write selection
  always_comb begin
    ram_addr = '0;
    ram_we   = 1'b0;
    wword    = cw;
    unique case (cmd.step)
      ST_CLR: begin
        ram_addr = clr_cnt;
        ram_we   = 1'b1;
        wword    = (clr_cnt == '0) ? init_ent : '0;
      end
      ST_DEC:   ram_addr = e_idx[ADDR_W-1:0];
      ST_SCAN:  ram_addr = h_val[ADDR_W-1:0];
      ST_A_CHK: ram_addr = dout.next_cls[ADDR_W-1:0];
      ST_F_CHK: ram_addr = dout.next_phys[ADDR_W-1:0];
      ST_F_P0:  ram_addr = cw.prev_phys[ADDR_W-1:0];
      ST_A_SPLIT: begin
        ram_addr        = r_idx[ADDR_W-1:0];
        ram_we          = 1'b1;
        wword           = '0;
        wword.len       = r_len;
        wword.hdr_mark  = 1'b1;
        wword.free_mark = 1'b1;
        wword.next_phys = cw.next_phys;
        wword.prev_phys = cur;
        wword.next_cls  = h_val;
        wword.prev_cls  = NIL;
      end
      ST_A_FIN: begin
        ram_addr        = cur[ADDR_W-1:0];
        ram_we          = 1'b1;
        wword.free_mark = 1'b0;
      end
      ST_F_INS_P: begin
        ram_addr       = oidx[ADDR_W-1:0];
        ram_we         = 1'b1;
        wword          = ow;
        wword.next_cls = h_val;
        wword.prev_cls = NIL;
      end
      ST_F_WE: begin
        ram_addr = cur[ADDR_W-1:0];
        ram_we   = 1'b1;
      end
      ST_F_INS_E: begin
        ram_addr       = cur[ADDR_W-1:0];
        ram_we         = 1'b1;
        wword.next_cls = h_val;
        wword.prev_cls = NIL;
      end
      ST_DR_RD: ram_addr = q[sel].addr[ADDR_W-1:0];
      ST_DR_WR: begin
        ram_addr = q[sel].addr[ADDR_W-1:0];
        ram_we   = 1'b1;
        wword    = patched;
      end
      default: ram_addr = '0;
    endcase
  end

  // status toward the sequencer
  always_comb begin
    sts          = '0;
    sts.dec_fail = (req.op == OP_FREE) ? f_fail : a_fail;
    sts.is_free  = (req.op == OP_FREE);
    sts.h_nil    = (h_val == NIL);
    sts.cls_last = (cls == CLS_W'(SIZE_CLASSES - 1));
    sts.fit      = dout.free_mark && ({1'b0, dout.len} >= need);
    sts.nxt_nil  = (dout.next_cls == NIL);
    sts.split    = ({1'b0, cw.len} >= need + 17'(HEADER_BYTES + MIN_PAYLOAD)) &&
                   (r_sum < (IDX_W+1)'(ENTRIES));
    sts.chk_fail = !dout.hdr_mark || dout.free_mark;
    sts.np_nil   = (dout.next_phys == NIL);
    sts.pp_nil   = (cw.prev_phys == NIL);
    sts.p_free   = dout.free_mark;
    sts.clr_last = (clr_cnt == ADDR_W'(ENTRIES - 1));
    sts.pending  = any_vld;
    sts.more     = (n_vld > 3'd1);
    sts.out_busy = out_valid && out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      used    <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        heads[i] <= (i == SIZE_CLASSES - 1) ? IDX_W'(0) : NIL;
      end
      for (int i = 0; i < QSLOTS; i++) begin
        q[i].vld <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) enable <= cfg_wdata;

      // result register
      if (cmd.step == ST_FIN && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (cmd.step)
        ST_CLR: clr_cnt <= clr_cnt + ADDR_W'(1);
        ST_A_TAKE: begin
          q[0] <= '{vld: cw.prev_cls != NIL, addr: cw.prev_cls, fld: FLD_NC,
                    val: cw.next_cls};
          q[1] <= '{vld: cw.next_cls != NIL, addr: cw.next_cls, fld: FLD_PC,
                    val: cw.prev_cls};
          if (cw.prev_cls == NIL) heads[h_idx] <= cw.next_cls;
        end
        ST_A_SPLIT: begin
          q[2] <= '{vld: cw.next_phys != NIL, addr: cw.next_phys, fld: FLD_PP,
                    val: r_idx};
          q[3] <= '{vld: h_val != NIL, addr: h_val, fld: FLD_PC, val: r_idx};
          heads[h_idx] <= r_idx;
        end
        ST_A_FIN: used <= used + {1'b0, cw.len} + 17'(HEADER_BYTES);
        ST_F_CHK: begin
          if (!sts.chk_fail) used <= used - {1'b0, dout.len} - 17'(HEADER_BYTES);
        end
        ST_F_N: begin
          if (dout.free_mark) begin
            q[0] <= '{vld: dout.prev_cls != NIL, addr: dout.prev_cls, fld: FLD_NC,
                      val: dout.next_cls};
            q[1] <= '{vld: dout.next_cls != NIL, addr: dout.next_cls, fld: FLD_PC,
                      val: dout.prev_cls};
            q[2] <= '{vld: dout.next_phys != NIL, addr: dout.next_phys, fld: FLD_PP,
                      val: cur};
            if (dout.prev_cls == NIL) heads[h_idx] <= dout.next_cls;
          end
        end
        ST_F_P: begin
          if (dout.free_mark) begin
            q[0] <= '{vld: dout.prev_cls != NIL, addr: dout.prev_cls, fld: FLD_NC,
                      val: dout.next_cls};
            q[1] <= '{vld: dout.next_cls != NIL, addr: dout.next_cls, fld: FLD_PC,
                      val: dout.prev_cls};
            q[2] <= '{vld: cw.next_phys != NIL, addr: cw.next_phys, fld: FLD_PP,
                      val: cw.prev_phys};
            if (dout.prev_cls == NIL) heads[h_idx] <= dout.next_cls;
          end
        end
        ST_F_INS_P: begin
          q[3] <= '{vld: h_val != NIL, addr: h_val, fld: FLD_PC, val: oidx};
          heads[h_idx] <= oidx;
        end
        ST_F_INS_E: begin
          q[0] <= '{vld: h_val != NIL, addr: h_val, fld: FLD_PC, val: cur};
          heads[h_idx] <= cur;
        end
        ST_DR_WR: q[sel].vld <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step == ST_FIN && !(out_valid && out_stall)) begin
      out_item <= '{status: stat, granted_offset: grant, used_bytes: used};
    end
    unique case (cmd.step)
      ST_IDLE: if (in_valid) req <= in_item;
      ST_DEC: begin
        stat  <= (req.op == OP_FREE) ? f_stat : a_stat;
        grant <= '0;
        need  <= need_c;
        cls   <= class_of(need_c);
        cur   <= e_idx;
      end
      ST_SCAN: begin
        if (h_val == NIL) begin
          if (sts.cls_last) stat <= STAT_OOM;
          else cls <= cls + CLS_W'(1);
        end else begin
          cur <= h_val;
        end
      end
      ST_A_CHK: begin
        if (sts.fit) begin
          cw <= dout;
        end else if (!sts.nxt_nil) begin
          cur <= dout.next_cls;
        end else if (sts.cls_last) begin
          stat <= STAT_OOM;
        end else begin
          cls <= cls + CLS_W'(1);
        end
      end
      ST_A_TAKE: begin
        cw.next_cls <= NIL;
        cw.prev_cls <= NIL;
      end
      ST_A_SPLIT: begin
        cw.len       <= need[15:0];
        cw.next_phys <= r_idx;
      end
      ST_A_FIN: grant <= {cur[ADDR_W-1:0], 3'b000} + 16'(HEADER_BYTES);
      ST_F_CHK: begin
        if (!dout.hdr_mark) stat <= STAT_NOT_HDR;
        else if (dout.free_mark) stat <= STAT_DBL_FREE;
        cw <= chk_ent;
      end
      ST_F_N: begin
        if (dout.free_mark) begin
          cw.len       <= cw.len + 16'(HEADER_BYTES) + dout.len;
          cw.next_phys <= dout.next_phys;
        end
      end
      ST_F_P: begin
        oidx <= cw.prev_phys;
        ow   <= mrg_ent;
      end
      default: ;
    endcase
  end

endmodule

### src/segregated_free_list_allocator_top.sv
// top level of the segregated free list allocator
//
// heap allocator over a 64 KiB region kept as 8192 granule entries in one ram.
// input channel (in_valid / in_stall) carries one request item: op 0 allocates
// request_size bytes, op 1 frees payload_offset. every request gives exactly
// one result item on the output channel (out_valid / out_stall) with status,
// granted offset and bytes in use.
// one request at a time, set by the single ram port: a new request is taken only
// after the last one has finished; an allocation walks empty classes and the
// blocks on the class lists, may split the block that fits, and then updates
// links; a free may merge with both neighbours.
// cfg_we writes allocator_enable from cfg_wdata; write only while idle.
// after reset a clearing pass over all 8192 entries initializes the entry ram, with
// in_stall high; configuration writes are taken during that pass.
// a result waits in the output register while out_stall is high; the next
// request is taken only after the result has been loaded into that register.
module segregated_free_list_allocator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfla_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sfla_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import sfla_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfla_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // requests are taken only in the idle step
  assign in_stall = (cmd.step != ST_IDLE);

  // an accepted item leaves the idle step
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (cmd.step == ST_DEC))
    else $error("accepted item did not start decode");

  // a patch write always follows its read
  a_patch_pair: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == ST_DR_WR) |-> ($past(cmd.step) == ST_DR_RD))
    else $error("patch write without read");

  // a finishing step with a free output slot produces a result
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == ST_FIN && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished item not presented");

endmodule
